// ----- hdl/jsu_pkg.sv -----
// Shared types, character codes and UTF-8 helpers for the JSON string unescaper.
package jsu_pkg;

  localparam int unsigned MaxRun = 6;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_LC_B  = 8'h62;
  localparam logic [7:0] CH_LC_F  = 8'h66;
  localparam logic [7:0] CH_LC_N  = 8'h6E;
  localparam logic [7:0] CH_LC_R  = 8'h72;
  localparam logic [7:0] CH_LC_T  = 8'h74;
  localparam logic [7:0] CH_LC_U  = 8'h75;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_FF    = 8'h0C;

  localparam logic [20:0] CP_REPLACEMENT = 21'h00FFFD;
  localparam logic [20:0] CP_SUPP_BASE   = 21'h010000;
  localparam logic [5:0]  SURR_HIGH_TAG  = 6'b110110;
  localparam logic [5:0]  SURR_LOW_TAG   = 6'b110111;

  localparam logic [7:0] FFFD_B0 = 8'hEF;
  localparam logic [7:0] FFFD_B1 = 8'hBF;
  localparam logic [7:0] FFFD_B2 = 8'hBD;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  typedef struct packed {
    logic [3:0][7:0] b;
    logic [2:0]      len;
  } utf8_t;

  typedef struct packed {
    logic [MaxRun-1:0][7:0] bytes;
    logic [2:0]             count;
    logic                   status_only;
    logic                   done;
    logic                   err;
  } run_t;

  function automatic hex_t hex_digit(input logic [7:0] c);
    hex_t r;
    r.ok  = 1'b1;
    r.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.val = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r.val = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r.val = 4'(c - 8'h37);
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

  function automatic utf8_t utf8_enc(input logic [20:0] cp);
    utf8_t r;
    r.b = '0;
    if (cp < 21'h000080) begin
      r.b[0] = cp[7:0];
      r.len  = 3'd1;
    end else if (cp < 21'h000800) begin
      r.b[0] = {3'b110, cp[10:6]};
      r.b[1] = {2'b10, cp[5:0]};
      r.len  = 3'd2;
    end else if (cp < 21'h010000) begin
      r.b[0] = {4'b1110, cp[15:12]};
      r.b[1] = {2'b10, cp[11:6]};
      r.b[2] = {2'b10, cp[5:0]};
      r.len  = 3'd3;
    end else begin
      r.b[0] = {5'b11110, cp[20:18]};
      r.b[1] = {2'b10, cp[17:12]};
      r.b[2] = {2'b10, cp[11:6]};
      r.b[3] = {2'b10, cp[5:0]};
      r.len  = 3'd4;
    end
    return r;
  endfunction

endpackage

// ----- hdl/json_string_unescape_utf8_core.sv -----
// JSON string unescaper top level: input register, decoder and output run register.
// One document byte is taken per item on the in_ channel; each accepted byte is
// registered, then decoded, and its run of zero to six result items is written
// into the output register once that register is free. A byte that yields at most
// one result moves through at one item per cycle while out_tready is high; a byte
// that yields k results holds the output register until all k items have left,
// and the input side stalls until the last item of the run leaves. Escapes and
// surrogate pairs are decoded to UTF-8; parse_error or string_done marks the
// last item of a run, and a byte that only finishes or fails a string gives a
// single item with byte_valid low.
module json_string_unescape_utf8_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast,
  output logic [2:0] out_tuser   // [0] byte_valid, [1] string_done, [2] parse_error
);

  logic          in_valid_r;
  logic [7:0]    in_byte_r;
  logic          in_eod_r;
  logic          buf_free, step;
  jsu_pkg::run_t run;

  assign step      = in_valid_r && buf_free;
  assign in_tready = !in_valid_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_eod_r  <= in_tlast;
    end
  end

  jsu_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .in_byte (in_byte_r),
    .eod     (in_eod_r),
    .run     (run)
  );

  jsu_run_buf u_run_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (step),
    .run        (run),
    .free       (buf_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

// ----- hdl/jsu_decode.sv -----
// Decoder state and per-byte unescape logic that builds one run of output bytes.
module jsu_decode (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        in_byte,
  input  logic              eod,
  output jsu_pkg::run_t     run
);

  typedef enum logic [6:0] {
    MODE_IDLE       = 7'b0000001,
    MODE_BODY       = 7'b0000010,
    MODE_ESC        = 7'b0000100,
    MODE_HEX        = 7'b0001000,
    MODE_AFTER_HIGH = 7'b0010000,
    MODE_PAIR_U     = 7'b0100000,
    MODE_PAIR_HEX   = 7'b1000000
  } mode_t;

  typedef struct packed {
    mode_t      mode;
    logic       on;
    logic [7:0] byte_val;
    logic       done;
    logic       err;
    logic       hex_start;
  } sub_t;

  mode_t       mode_r, mode_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [9:0]  ph_r, ph_nxt;

  jsu_pkg::hex_t  hx;
  jsu_pkg::utf8_t enc;
  sub_t           body_s, esc_s;
  logic [15:0]    acc_shift;
  logic           hex_full, fin_high, fin_low;
  logic           err, done, pre, t_on, t_raw;
  logic [7:0]     t_byte;
  logic [20:0]    t_cp;
  logic [3:0][7:0] tb;
  logic [2:0]     tlen, total;

  assign hx        = jsu_pkg::hex_digit(in_byte);
  assign acc_shift = {acc_r[11:0], hx.val};
  assign hex_full  = (cnt_r == 2'd3);
  assign fin_high  = (acc_shift[15:10] == jsu_pkg::SURR_HIGH_TAG);
  assign fin_low   = (acc_shift[15:10] == jsu_pkg::SURR_LOW_TAG);

  always_comb begin
    body_s           = '0;
    body_s.byte_val  = in_byte;
    body_s.mode      = MODE_BODY;
    if (in_byte == jsu_pkg::CH_QUOTE) begin
      body_s.done = 1'b1;
      body_s.mode = MODE_IDLE;
    end else if (in_byte == jsu_pkg::CH_BSL) begin
      body_s.mode = MODE_ESC;
    end else begin
      body_s.on = 1'b1;
    end
  end

  always_comb begin
    esc_s          = '0;
    esc_s.mode     = MODE_BODY;
    esc_s.byte_val = in_byte;
    case (in_byte)
      jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSL, jsu_pkg::CH_SLASH: esc_s.on = 1'b1;
      jsu_pkg::CH_LC_B: begin
        esc_s.on       = 1'b1;
        esc_s.byte_val = jsu_pkg::CH_BS;
      end
      jsu_pkg::CH_LC_F: begin
        esc_s.on       = 1'b1;
        esc_s.byte_val = jsu_pkg::CH_FF;
      end
      jsu_pkg::CH_LC_N: begin
        esc_s.on       = 1'b1;
        esc_s.byte_val = jsu_pkg::CH_LF;
      end
      jsu_pkg::CH_LC_R: begin
        esc_s.on       = 1'b1;
        esc_s.byte_val = jsu_pkg::CH_CR;
      end
      jsu_pkg::CH_LC_T: begin
        esc_s.on       = 1'b1;
        esc_s.byte_val = jsu_pkg::CH_TAB;
      end
      jsu_pkg::CH_LC_U: begin
        esc_s.mode      = MODE_HEX;
        esc_s.hex_start = 1'b1;
      end
      default: esc_s.err = 1'b1;
    endcase
  end

  always_comb begin
    mode_nxt = mode_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    ph_nxt   = ph_r;
    err      = 1'b0;
    done     = 1'b0;
    pre      = 1'b0;
    t_on     = 1'b0;
    t_raw    = 1'b0;
    t_byte   = in_byte;
    t_cp     = '0;
    case (mode_r)
      MODE_IDLE: begin
        if (in_byte == jsu_pkg::CH_QUOTE) begin
          mode_nxt = MODE_BODY;
        end else if (!(in_byte == jsu_pkg::CH_SPACE || in_byte == jsu_pkg::CH_TAB ||
                       in_byte == jsu_pkg::CH_CR || in_byte == jsu_pkg::CH_LF)) begin
          err = 1'b1;
        end
      end
      MODE_BODY: begin
        mode_nxt = body_s.mode;
        done     = body_s.done;
        t_on     = body_s.on;
        t_raw    = body_s.on;
      end
      MODE_ESC: begin
        mode_nxt = esc_s.mode;
        err      = esc_s.err;
        t_on     = esc_s.on;
        t_raw    = esc_s.on;
        t_byte   = esc_s.byte_val;
        if (esc_s.hex_start) begin
          acc_nxt = '0;
          cnt_nxt = '0;
        end
      end
      MODE_AFTER_HIGH: begin
        if (in_byte == jsu_pkg::CH_BSL) begin
          mode_nxt = MODE_PAIR_U;
        end else begin
          pre      = 1'b1;
          mode_nxt = body_s.mode;
          done     = body_s.done;
          t_on     = body_s.on;
          t_raw    = body_s.on;
        end
      end
      MODE_PAIR_U: begin
        if (in_byte == jsu_pkg::CH_LC_U) begin
          mode_nxt = MODE_PAIR_HEX;
          acc_nxt  = '0;
          cnt_nxt  = '0;
        end else begin
          pre      = 1'b1;
          mode_nxt = esc_s.mode;
          err      = esc_s.err;
          t_on     = esc_s.on;
          t_raw    = esc_s.on;
          t_byte   = esc_s.byte_val;
        end
      end
      MODE_HEX, MODE_PAIR_HEX: begin
        if (!hx.ok) begin
          err = 1'b1;
        end else begin
          acc_nxt = acc_shift;
          cnt_nxt = 2'(cnt_r + 2'd1);
          if (hex_full) begin
            cnt_nxt = '0;
            if (mode_r == MODE_PAIR_HEX && fin_low) begin
              t_on     = 1'b1;
              t_cp     = 21'(jsu_pkg::CP_SUPP_BASE + {11'd0, ph_r, acc_shift[9:0]});
              mode_nxt = MODE_BODY;
            end else begin
              pre = (mode_r == MODE_PAIR_HEX);
              if (fin_high) begin
                ph_nxt   = acc_shift[9:0];
                mode_nxt = MODE_AFTER_HIGH;
              end else begin
                t_on     = 1'b1;
                t_cp     = fin_low ? jsu_pkg::CP_REPLACEMENT : {5'd0, acc_shift};
                mode_nxt = MODE_BODY;
              end
            end
          end
        end
      end
      default: err = 1'b1;
    endcase
    if (eod && !done) begin
      err = 1'b1;
    end
    if (err) begin
      mode_nxt = MODE_IDLE;
      acc_nxt  = '0;
      cnt_nxt  = '0;
      ph_nxt   = '0;
    end
  end

  assign enc  = jsu_pkg::utf8_enc(t_cp);
  assign tb   = t_raw ? {24'd0, t_byte} : enc.b;
  assign tlen = !t_on ? 3'd0 : (t_raw ? 3'd1 : enc.len);
  assign total = 3'(tlen + (pre ? 3'd3 : 3'd0));

  always_comb begin
    run.bytes = '0;
    if (pre) begin
      run.bytes[0] = jsu_pkg::FFFD_B0;
      run.bytes[1] = jsu_pkg::FFFD_B1;
      run.bytes[2] = jsu_pkg::FFFD_B2;
      run.bytes[3] = tb[0];
      run.bytes[4] = tb[1];
      run.bytes[5] = tb[2];
    end else begin
      run.bytes[0] = tb[0];
      run.bytes[1] = tb[1];
      run.bytes[2] = tb[2];
      run.bytes[3] = tb[3];
    end
    run.done        = done;
    run.err         = err;
    run.status_only = (total == 3'd0) && (done || err);
    run.count       = run.status_only ? 3'd1 : total;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      acc_r  <= '0;
      cnt_r  <= '0;
      ph_r   <= '0;
    end else if (step) begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      cnt_r  <= cnt_nxt;
      ph_r   <= ph_nxt;
    end
  end

endmodule

// ----- hdl/jsu_run_buf.sv -----
// Result register that holds one run of output bytes and hands them out one per cycle while out_tready is high.
module jsu_run_buf (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  jsu_pkg::run_t run,
  output logic          free,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [7:0]    out_tdata,
  output logic          out_tlast,
  output logic [2:0]    out_tuser
);

  logic [jsu_pkg::MaxRun-1:0][7:0] bytes_r;
  logic [2:0] count_r, count_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic       status_r, done_r, err_r;
  logic       last, fire;

  assign out_tvalid = (count_r != 3'd0);
  assign last       = (3'(idx_r + 3'd1) == count_r);
  assign fire       = out_tvalid && out_tready;
  assign free       = !out_tvalid || (out_tready && last);

  assign out_tdata    = bytes_r[idx_r];
  assign out_tlast    = last;
  assign out_tuser[0] = !status_r;
  assign out_tuser[1] = last && done_r;
  assign out_tuser[2] = last && err_r;

  always_comb begin
    count_nxt = count_r;
    idx_nxt   = idx_r;
    if (load) begin
      count_nxt = run.count;
      idx_nxt   = '0;
    end else if (fire) begin
      if (last) begin
        count_nxt = '0;
        idx_nxt   = '0;
      end else begin
        idx_nxt = 3'(idx_r + 3'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      idx_r   <= '0;
    end else begin
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes_r  <= run.bytes;
      status_r <= run.status_only;
      done_r   <= run.done;
      err_r    <= run.err;
    end
  end

  a_flags_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !out_tuser[1] && !out_tuser[2])
    else $error("status flag on a non-final item");

  a_status_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tlast && (out_tuser[1] || out_tuser[2]))
    else $error("status-only item without a flag or not last");

  a_idx_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> idx_r < count_r)
    else $error("run index beyond run length");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid && idx_r == $past(idx_r) + 3'd1)
    else $error("run broken before its last item");

endmodule
